// ===== design/hvn_pkg.sv =====
// shared types, constants and helpers of the heightfield vertex normal block
// used by every module of the block but hvn_ram; depends on nothing

package hvn_pkg;

  localparam int unsigned MAX_GRID  = 256;
  localparam int unsigned GRID_AW   = $clog2(MAX_GRID);
  localparam int unsigned SLOT_AW   = GRID_AW + 1;
  localparam int unsigned SIDE_W    = GRID_AW + 1;
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_AW    = $clog2(JOB_DEPTH);

  localparam logic [SIDE_W-1:0] GRID_RESET = SIDE_W'(50);

  // component select of the normalizing unit
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // one completed cell, handed from the front to the back
  typedef struct packed {
    logic signed [16:0] lx;
    logic signed [16:0] ly;
    logic signed [16:0] ux;
    logic signed [16:0] uy;
    logic [GRID_AW-1:0] a;
    logic [GRID_AW-1:0] b;
    logic               last_col;
    logic               last_row;
    logic [GRID_AW-1:0] nm1;
  } job_t;

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    logic [16:0] t;
    t = v[16] ? 17'(-v) : 17'(v);
    return t[15:0];
  endfunction

  // apply sign to a magnitude of at most 32768, saturating the positive side
  function automatic logic signed [15:0] sat_sign(logic neg, logic [16:0] q);
    logic [16:0] t;
    t = 17'd0 - q;
    if (neg) begin
      return signed'(t[15:0]);
    end else if (q > 17'd32767) begin
      return 16'sh7fff;
    end else begin
      return signed'(q[15:0]);
    end
  endfunction

endpackage

// ===== design/hvn_ram.sv =====
// generic simple dual port ram with registered read, old data on collision
// no package dependency

module hvn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hvn_front.sv =====
// front end: takes heights in raster order, keeps the height line and
// builds one job per completed cell; uses hvn_pkg and hvn_ram

module hvn_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic signed [15:0]         height_i,
  output logic                       full_o,
  input  logic [hvn_pkg::SIDE_W-1:0] side_i,
  input  logic                       cfg_we_i,
  input  logic                       job_full_i,
  output logic                       job_push_o,
  output hvn_pkg::job_t              job_o
);
  import hvn_pkg::*;

  logic               busy_q;
  logic [GRID_AW-1:0] row_q, col_q, pi_q, pk_q;
  logic signed [15:0] cur_q, left_q, ul_q, up;
  logic               accept, need, finish;
  logic [SIDE_W-1:0]  col_inc, row_inc, side_m1;
  logic [15:0]        up_raw;

  assign accept  = push_i && !busy_q;
  assign full_o  = busy_q;
  assign col_inc = {1'b0, col_q} + SIDE_W'(1);
  assign row_inc = {1'b0, row_q} + SIDE_W'(1);
  assign side_m1 = side_i - SIDE_W'(1);

  // read stays on the held column until its new height is written back
  hvn_ram #(.WIDTH(16), .DEPTH(MAX_GRID)) u_line (
    .clk_i   (clk_i),
    .we_i    (finish),
    .waddr_i (pk_q),
    .wdata_i (cur_q),
    .raddr_i (busy_q ? pk_q : col_q),
    .rdata_o (up_raw)
  );

  assign up     = signed'(up_raw);
  assign need   = (pi_q != '0) && (pk_q != '0);
  assign finish = busy_q && (!need || !job_full_i);

  assign job_push_o = busy_q && need && !job_full_i;

  always_comb begin
    job_o          = '0;
    job_o.lx       = 17'(ul_q) - 17'(left_q);
    job_o.ly       = 17'(left_q) - 17'(cur_q);
    job_o.ux       = 17'(up) - 17'(cur_q);
    job_o.uy       = 17'(ul_q) - 17'(up);
    job_o.a        = pi_q - GRID_AW'(1);
    job_o.b        = pk_q - GRID_AW'(1);
    job_o.last_col = ({1'b0, pk_q} == side_m1);
    job_o.last_row = ({1'b0, pi_q} == side_m1);
    job_o.nm1      = side_m1[GRID_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
      ul_q   <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        if (col_inc == side_i) begin
          col_q <= '0;
          row_q <= (row_inc == side_i) ? '0 : row_inc[GRID_AW-1:0];
        end else begin
          col_q <= col_inc[GRID_AW-1:0];
        end
      end
      if (finish) begin
        busy_q <= 1'b0;
        left_q <= cur_q;
        ul_q   <= up;
      end
      if (cfg_we_i) begin
        row_q  <= '0;
        col_q  <= '0;
        left_q <= '0;
        ul_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= height_i;
      pi_q  <= row_q;
      pk_q  <= col_q;
    end
  end

endmodule

// ===== design/hvn_fifo.sv =====
// two entry job queue between front and back end
// uses hvn_pkg for the job type

module hvn_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hvn_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hvn_pkg::job_t data_o,
  output logic          empty_o
);
  import hvn_pkg::*;

  job_t              mem_q [JOB_DEPTH];
  logic [JOB_AW-1:0] wptr_q, rptr_q;
  logic [JOB_AW:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (JOB_AW+1)'(JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + JOB_AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + JOB_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (JOB_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (JOB_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== design/hvn_unit.sv =====
// normalizing unit: one q1.15 component of a unit triangle normal through
// a shared squarer, a restoring divider and a bitwise square root; uses hvn_pkg

module hvn_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] x_i,
  input  logic signed [16:0] y_i,
  input  logic [1:0]         comp_i,
  output logic               done_o,
  output logic signed [15:0] value_o
);
  import hvn_pkg::*;

  typedef enum logic [2:0] {U_IDLE, U_SQX, U_SQY, U_SQM, U_DIV, U_SQRT} state_e;

  state_e             state_q;
  logic signed [16:0] x_q, y_q;
  logic [1:0]         comp_q;
  logic [32:0]        acc_q, s_q;
  logic [34:0]        rem_q;
  logic [31:0]        quo_q, num_q, res_q, bit_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic signed [15:0] val_q;

  logic [15:0] op;
  logic [31:0] prod;
  logic [34:0] r2, rem_d;
  logic        ge;
  logic [31:0] quo_d, num_d, res_d;
  logic [32:0] trial;
  logic        ge2;
  logic [16:0] c;
  logic        neg;

  always_comb begin
    case (state_q)
      U_SQX:   op = mag17(x_q);
      U_SQY:   op = mag17(y_q);
      default: begin
        if (comp_q == COMP_X) begin
          op = mag17(x_q);
        end else if (comp_q == COMP_Y) begin
          op = mag17(y_q);
        end else begin
          op = 16'd256;
        end
      end
    endcase
  end

  assign prod = op * op;

  // one quotient bit a cycle: m^2 * 2^32 / s
  assign r2    = {rem_q[33:0], 1'b0};
  assign ge    = r2 >= {2'b0, s_q};
  assign rem_d = ge ? r2 - {2'b0, s_q} : r2;
  assign quo_d = {quo_q[30:0], ge};

  // one root bit a cycle
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign ge2   = {1'b0, num_q} >= trial;
  assign num_d = ge2 ? num_q - trial[31:0] : num_q;
  assign res_d = ge2 ? (res_q >> 1) + bit_q : (res_q >> 1);

  // largest c with (2c-1)^2 <= q is (isqrt(q)+1)/2
  assign c   = ({1'b0, res_d[15:0]} + 17'd1) >> 1;
  assign neg = (comp_q == COMP_X) ? x_q[16] : ((comp_q == COMP_Y) ? y_q[16] : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        U_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            y_q     <= y_i;
            comp_q  <= comp_i;
            state_q <= U_SQX;
          end
        end
        U_SQX: begin
          acc_q   <= {1'b0, prod};
          state_q <= U_SQY;
        end
        U_SQY: begin
          s_q     <= acc_q + {1'b0, prod} + 33'd65536;
          state_q <= U_SQM;
        end
        U_SQM: begin
          rem_q   <= {3'b0, prod};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= U_DIV;
        end
        U_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            num_q   <= quo_d;
            res_q   <= '0;
            bit_q   <= 32'h4000_0000;
            cnt_q   <= '0;
            state_q <= U_SQRT;
          end
        end
        U_SQRT: begin
          num_q <= num_d;
          res_q <= res_d;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) begin
            val_q   <= sat_sign(neg, c);
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = val_q;

endmodule

// ===== design/hvn_back.sv =====
// back end: normalizes both triangles of a cell, keeps two cell rows of
// triangle normals, averages and emits the vertex normals
// uses hvn_pkg, hvn_unit and hvn_ram

module hvn_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_empty_i,
  input  hvn_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [hvn_pkg::GRID_AW-1:0] row_o,
  output logic [hvn_pkg::GRID_AW-1:0] col_o,
  output logic signed [15:0]          norm_x_o,
  output logic signed [15:0]          norm_y_o,
  output logic signed [15:0]          norm_z_o,
  output logic                        last_of_run_o
);
  import hvn_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_START, B_WAIT, B_WR, B_RD1, B_RD2, B_AS, B_AM, B_AF, B_EMIT
  } state_e;

  state_e             state_q;
  job_t               job_q;
  logic               tri_q;
  logic [1:0]         comp_q, t_q;
  logic signed [15:0] lo_q [3];
  logic signed [15:0] up_q [3];
  logic signed [15:0] v_q [3];
  logic signed [15:0] w_q [3];
  logic [47:0]        ucl_q, lcu_q, ucu_q, lcp_q;
  logic [16:0]        y_q, qdiv_q;
  logic               neg_q, half_q;
  logic [3:0]         pend_q;

  logic               out_valid_q, last_q;
  logic [GRID_AW-1:0] orow_q, ocol_q;
  logic signed [15:0] ox_q, oy_q, oz_q;

  logic               start, done;
  logic signed [15:0] uval;
  logic [SLOT_AW-1:0] c0, cl, cu, cp, u_raddr, l_raddr;
  logic [47:0]        u_rd, l_rd;
  logic [GRID_AW-1:0] bm1;

  logic signed [18:0] sum;
  logic [18:0]        smag;
  logic               sden6, sden2;
  logic [16:0]        sy;
  logic signed [16:0] ws;
  logic [16:0]        wmag, wq;
  logic [33:0]        prod3;
  logic [3:0]         low, rest;
  logic               out_free;

  assign start = (state_q == B_START);

  hvn_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .x_i     (tri_q ? job_q.ux : job_q.lx),
    .y_i     (tri_q ? job_q.uy : job_q.ly),
    .comp_i  (comp_q),
    .done_o  (done),
    .value_o (uval)
  );

  // even and odd cell rows sit in the two halves of each store
  assign bm1 = job_q.b - GRID_AW'(1);
  assign c0  = {job_q.a[0], job_q.b};
  assign cl  = {job_q.a[0], bm1};
  assign cu  = {~job_q.a[0], bm1};
  assign cp  = {~job_q.a[0], job_q.b};

  assign u_raddr = (state_q == B_RD1) ? cu : cl;
  assign l_raddr = (state_q == B_RD1) ? cp : cu;

  hvn_ram #(.WIDTH(48), .DEPTH(2 * MAX_GRID)) u_upper (
    .clk_i   (clk_i),
    .we_i    (state_q == B_WR),
    .waddr_i (c0),
    .wdata_i ({up_q[2], up_q[1], up_q[0]}),
    .raddr_i (u_raddr),
    .rdata_o (u_rd)
  );

  hvn_ram #(.WIDTH(48), .DEPTH(2 * MAX_GRID)) u_lower (
    .clk_i   (clk_i),
    .we_i    (state_q == B_WR),
    .waddr_i (c0),
    .wdata_i ({lo_q[2], lo_q[1], lo_q[0]}),
    .raddr_i (l_raddr),
    .rdata_o (l_rd)
  );

  // sum of the triangles around the vertex for component t
  always_comb begin
    sum   = 19'(up_q[t_q]) + 19'(lo_q[t_q]);
    sden6 = 1'b0;
    sden2 = 1'b0;
    if (job_q.a != '0 && job_q.b != '0) begin
      sum = sum + 19'(signed'(ucl_q[16*t_q +: 16])) + 19'(signed'(ucu_q[16*t_q +: 16]))
          + 19'(signed'(lcu_q[16*t_q +: 16])) + 19'(signed'(lcp_q[16*t_q +: 16]));
      sden6 = 1'b1;
    end else if (job_q.a == '0 && job_q.b == '0) begin
      sden2 = 1'b1;
    end else if (job_q.a == '0) begin
      sum = sum + 19'(signed'(ucl_q[16*t_q +: 16]));
    end else begin
      sum = sum + 19'(signed'(lcp_q[16*t_q +: 16]));
    end
    smag = sum[18] ? 19'(-sum) : 19'(sum);
    // x/6 is taken as (x/2)/3
    sy   = sden6 ? 17'((smag + 19'd3) >> 1) : 17'(smag + 19'd1);
    ws   = 17'(up_q[t_q]) + 17'(lo_q[t_q]);
    wmag = ws[16] ? 17'(-ws) : 17'(ws);
    wq   = 17'((18'(wmag) + 18'd1) >> 1);
  end

  // exact floor(y/3) for y below 2^17
  assign prod3 = y_q * 17'd43691;

  assign low      = pend_q & (~pend_q + 4'd1);
  assign rest     = pend_q & ~low;
  assign out_free = !out_valid_q || pop_i;

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            tri_q   <= 1'b0;
            comp_q  <= COMP_X;
            state_q <= B_START;
          end
        end
        B_START: state_q <= B_WAIT;
        B_WAIT: begin
          if (done) begin
            if (tri_q) begin
              up_q[comp_q] <= uval;
            end else begin
              lo_q[comp_q] <= uval;
            end
            if (comp_q == COMP_Z) begin
              comp_q  <= COMP_X;
              tri_q   <= 1'b1;
              state_q <= tri_q ? B_WR : B_START;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= B_START;
            end
          end
        end
        B_WR: state_q <= B_RD1;
        B_RD1: begin
          ucl_q   <= u_rd;
          lcu_q   <= l_rd;
          state_q <= B_RD2;
        end
        B_RD2: begin
          ucu_q   <= u_rd;
          lcp_q   <= l_rd;
          t_q     <= COMP_X;
          state_q <= B_AS;
        end
        B_AS: begin
          y_q       <= sy;
          neg_q     <= sum[18];
          half_q    <= sden2;
          w_q[t_q]  <= sat_sign(ws[16], wq);
          state_q   <= B_AM;
        end
        B_AM: begin
          qdiv_q  <= half_q ? (y_q >> 1) : 17'(prod3 >> 17);
          state_q <= B_AF;
        end
        B_AF: begin
          v_q[t_q] <= sat_sign(neg_q, qdiv_q);
          if (t_q == COMP_Z) begin
            pend_q  <= {job_q.last_col && job_q.last_row, job_q.last_row,
                        job_q.last_col, 1'b1};
            state_q <= B_EMIT;
          end else begin
            t_q     <= t_q + 2'd1;
            state_q <= B_AS;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            last_q      <= (rest == '0);
            ox_q        <= v_q[0];
            oy_q        <= v_q[1];
            oz_q        <= v_q[2];
            if (low[0]) begin
              orow_q <= job_q.a;
              ocol_q <= job_q.b;
            end else if (low[1]) begin
              orow_q <= job_q.a;
              ocol_q <= job_q.nm1;
            end else if (low[2]) begin
              orow_q <= job_q.nm1;
              ocol_q <= job_q.b;
            end else begin
              // far corner uses its own two-term average
              orow_q <= job_q.nm1;
              ocol_q <= job_q.nm1;
              ox_q   <= w_q[0];
              oy_q   <= w_q[1];
              oz_q   <= w_q[2];
            end
            pend_q <= rest;
            if (rest == '0) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty_o       = !out_valid_q;
  assign row_o         = orow_q;
  assign col_o         = ocol_q;
  assign norm_x_o      = ox_q;
  assign norm_y_o      = oy_q;
  assign norm_z_o      = oz_q;
  assign last_of_run_o = last_q;

endmodule

// ===== design/heightfield_vertex_normals.sv =====
// heightfield vertex normals: a height that completes a cell is worked through six unit components,
// one after another in the shared divider and root unit, then store access, averaging and the
// emission of its vertex normals.
// heights in row 0 or column 0 pass through the front and emit nothing.
// the front runs up to three jobs ahead of the back: two queued, one held.
// reset: grid size 50, frame position (0,0); stores need no clearing pass.

module heightfield_vertex_normals (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] height_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         row_o,
  output logic [7:0]         col_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [8:0]         cfg_data_i
);
  import hvn_pkg::*;

  logic [8:0]        grid_q;
  logic [9:0]        even;
  logic [SIDE_W-1:0] side;
  job_t              fjob, bjob;
  logic              jpush, jfull, jpop, jempty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  // odd sizes round up, then clamp to the supported range
  always_comb begin
    even = {1'b0, grid_q} + {9'd0, grid_q[0]};
    if (even < 10'd2) begin
      side = SIDE_W'(2);
    end else if (even > 10'(MAX_GRID)) begin
      side = SIDE_W'(MAX_GRID);
    end else begin
      side = even[SIDE_W-1:0];
    end
  end

  hvn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .height_i   (height_i),
    .full_o     (full),
    .side_i     (side),
    .cfg_we_i   (cfg_valid_i),
    .job_full_i (jfull),
    .job_push_o (jpush),
    .job_o      (fjob)
  );

  hvn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jpush),
    .data_i  (fjob),
    .full_o  (jfull),
    .pop_i   (jpop),
    .data_o  (bjob),
    .empty_o (jempty)
  );

  hvn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_empty_i   (jempty),
    .job_i         (bjob),
    .job_pop_o     (jpop),
    .empty_o       (empty),
    .pop_i         (pop),
    .row_o         (row_o),
    .col_o         (col_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
